// File: hdl/wps_pkg.sv
// Shared types, constants and tables for the waypoint PID steering block.
package wps_pkg;

    // Vectoring steps of the bearing CORDIC and width of the error accumulators.
    localparam int CORDIC_STEPS = 16;
    localparam int SUM_W        = 48;

    // Serial multiplier operand widths.
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 33;
    localparam int MUL_N_W = 6;

    // Number of multiplier bits consumed by each kind of product.
    localparam logic [MUL_N_W-1:0] SQ_BITS   = 6'd33;
    localparam logic [MUL_N_W-1:0] GAIN_BITS = 6'd16;
    localparam logic [MUL_N_W-1:0] RATE_BITS = 6'd10;

    // Configuration register indexes.
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [2:0] REG_TICK_RATE   = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
    localparam logic [2:0] REG_ACCEL_LIMIT = 3'd5;
    localparam logic [2:0] REG_ARRIVE_THR  = 3'd6;

    // Pi and two pi in Q2.30 radians.
    localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;

    // One control tick request.
    typedef struct packed {
        logic               op;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_theta;
    } t_in_req;

    // One steering result.
    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic        [31:0] distance_error;
        logic signed [15:0] heading_error;
        logic               arrived;
    } t_out_req;

    // Command to a serial multiplier.
    typedef struct packed {
        logic               start;
        logic [MUL_N_W-1:0] nbits;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_cmd;

    // Arctangent of 2^-i in Q2.30, truncated.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'h3243F6A8;
            5'd1:  r = 30'h1DAC6705;
            5'd2:  r = 30'h0FADBAFC;
            5'd3:  r = 30'h07F56EA6;
            5'd4:  r = 30'h03FEAB76;
            5'd5:  r = 30'h01FFD55B;
            5'd6:  r = 30'h00FFFAAA;
            5'd7:  r = 30'h007FFF55;
            5'd8:  r = 30'h003FFFEA;
            5'd9:  r = 30'h001FFFFD;
            5'd10: r = 30'h000FFFFF;
            5'd11: r = 30'h0007FFFF;
            5'd12: r = 30'h0003FFFF;
            5'd13: r = 30'h0001FFFF;
            5'd14: r = 30'h0000FFFF;
            5'd15: r = 30'h00007FFF;
            5'd16: r = 30'h00003FFF;
            5'd17: r = 30'h00001FFF;
            5'd18: r = 30'h00000FFF;
            5'd19: r = 30'h000007FF;
            5'd20: r = 30'h000003FF;
            5'd21: r = 30'h000001FF;
            5'd22: r = 30'h000000FF;
            5'd23: r = 30'h0000007F;
            5'd24: r = 30'h0000003F;
            5'd25: r = 30'h0000001F;
            5'd26: r = 30'h0000000F;
            5'd27: r = 30'h00000008;
            5'd28: r = 30'h00000004;
            5'd29: r = 30'h00000002;
            5'd30: r = 30'h00000001;
            default: r = 30'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/wps_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module wps_smul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wps_pkg::t_mul_cmd            i_cmd,
    output logic                         o_busy,
    output logic [wps_pkg::MUL_A_W-1:0]  o_prod
);
    import wps_pkg::*;

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_A_W-1:0] r_acc;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_N_W-1:0] r_cnt;
    logic               r_busy;

    // Bit counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_cmd.nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == MUL_N_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Add the shifted multiplicand for every set multiplier bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a   <= i_cmd.a;
            r_b   <= i_cmd.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[MUL_A_W-2:0], 1'b0};
            r_b <= {1'b0, r_b[MUL_B_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

// File: hdl/waypoint_pid_steering_top.sv
// Top level of the go-to-goal PID steering block with its register port.
//
// Each accepted request is worked through in turn: two bit-serial multipliers
// square the offsets while a 16-step CORDIC finds the bearing, a restoring
// square root then finds the distance, the heading error is wrapped where it
// has to be, and the PID terms take four multiplier passes, each through the
// GO and WAIT states, distance and heading terms running side by side. The
// next request can be accepted in the same cycle as the result becomes valid.
// One request is worked on at a time; a finished result waits in the output
// register while the next request is accepted, and the block stalls before
// handing over a result while the previous one has not been taken.
// Registers sit at byte address 4*index and may be written only while idle.
module waypoint_pid_steering_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wps_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wps_pkg::t_out_req               o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wps_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import wps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SQR, S_ROOT, S_ERR, S_WRAP, S_SEED,
        S_GO, S_WAIT, S_DRIVE, S_SLEW, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_PROP, PH_DERIV, PH_RATE, PH_INTEG} t_phase;

    localparam logic [63:0] SAT_LIM  = 64'h1000_0000_0000_0000;
    localparam logic [63:0] SAT_PRE8 = 64'h0200_0000_0000_0000;

    t_state r_state;
    t_phase r_phase;

    // Configuration registers.
    logic [15:0] r_prop_gain, r_integ_gain, r_deriv_gain, r_arrive_thr;
    logic [9:0]  r_tick_rate;
    logic [14:0] r_speed_limit, r_accel_limit;

    // Request operands.
    logic               r_op;
    logic signed [15:0] r_theta;
    logic signed [32:0] r_dx, r_dy;

    // CORDIC.
    logic signed [35:0] r_cx, r_cy;
    logic signed [34:0] r_cz;
    logic [4:0]         r_cstep;
    logic               r_cbusy;

    // Square root.
    logic [65:0] r_rad;
    logic [36:0] r_rem;
    logic [32:0] r_root;
    logic [5:0]  r_scnt;

    // Errors and loop state.
    logic signed [34:0]      r_e;
    logic [31:0]             r_dist, r_prev_dist;
    logic signed [15:0]      r_head, r_prev_head;
    logic signed [SUM_W-1:0] r_dsum, r_hsum;
    logic signed [15:0]      r_prev_left, r_prev_right;
    logic signed [63:0]      r_common, r_turn;
    logic signed [15:0]      r_vl, r_vr;

    t_out_req r_out;
    logic     r_ovalid;

    // Multiplier connections.
    t_mul_cmd           n_cmd0, n_cmd1;
    logic               w_busy0, w_busy1;
    logic [MUL_A_W-1:0] w_prod0, w_prod1;

    // Combinational helpers.
    logic signed [32:0]      n_negdx, n_negdy;
    logic [31:0]             n_ax, n_ay;
    logic signed [32:0]      n_dd;
    logic [31:0]             n_dd_mag;
    logic signed [16:0]      n_dh;
    logic [16:0]             n_dh_mag;
    logic [15:0]             n_head_mag;
    logic signed [SUM_W-1:0] n_dsum_neg, n_hsum_neg;
    logic [SUM_W-1:0]        n_dsum_mag, n_hsum_mag;
    logic [63:0]             n_sat0, n_sat1;
    logic signed [63:0]      n_term0, n_term1;
    logic [64:0]             n_sq_sum;
    logic [36:0]             n_rem_sh, n_trial;
    logic signed [34:0]      n_theta_ext, n_e_rnd;
    logic signed [35:0]      n_xs, n_ys, n_sx, n_sy;
    logic signed [34:0]      n_at;
    logic signed [63:0]      n_ul, n_ur, n_rl, n_rr;
    logic signed [SUM_W:0]   n_dsum_s, n_hsum_s;

    // Saturate a widened accumulator sum back to the accumulator range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
        logic signed [SUM_W-1:0] r;
        if (s[SUM_W] != s[SUM_W-1]) begin
            r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = s[SUM_W-1:0];
        end
        return r;
    endfunction

    // Round a Q16 drive sum to whole units and clamp it to the speed limit.
    function automatic logic signed [15:0] clamp_speed(input logic signed [63:0] u,
                                                      input logic [14:0] lim);
        logic signed [47:0] v;
        logic signed [47:0] l;
        logic signed [47:0] nl;
        logic signed [15:0] r;
        v  = u[63:16];
        l  = $signed({33'b0, lim});
        nl = -l;
        if (v > l) begin
            r = l[15:0];
        end else if (v < nl) begin
            r = nl[15:0];
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Keep a drive within the acceleration limit of the last drive.
    function automatic logic signed [15:0] slew(input logic signed [15:0] v,
                                               input logic signed [15:0] last,
                                               input logic [14:0] acc);
        logic signed [17:0] hi;
        logic signed [17:0] lo;
        logic signed [17:0] w;
        logic signed [15:0] r;
        hi = 18'(last) + $signed({3'b0, acc});
        lo = 18'(last) - $signed({3'b0, acc});
        w  = 18'(v);
        if (w > hi) begin
            r = hi[15:0];
        end else if (w < lo) begin
            r = lo[15:0];
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Magnitudes and differences used by the products.
    always_comb begin
        n_negdx    = -r_dx;
        n_negdy    = -r_dy;
        n_ax       = r_dx[32] ? n_negdx[31:0] : r_dx[31:0];
        n_ay       = r_dy[32] ? n_negdy[31:0] : r_dy[31:0];
        n_dd       = $signed({1'b0, r_dist}) - $signed({1'b0, r_prev_dist});
        n_dd_mag   = n_dd[32] ? 32'(-n_dd) : n_dd[31:0];
        n_dh       = 17'(r_head) - 17'(r_prev_head);
        n_dh_mag   = n_dh[16] ? 17'(-n_dh) : n_dh;
        n_head_mag = r_head[15] ? 16'(-r_head) : r_head;
        n_dsum_neg = -r_dsum;
        n_hsum_neg = -r_hsum;
        n_dsum_mag = r_dsum[SUM_W-1] ? n_dsum_neg : r_dsum;
        n_hsum_mag = r_hsum[SUM_W-1] ? n_hsum_neg : r_hsum;
        n_sat0     = (w_prod0 > SAT_LIM) ? SAT_LIM : w_prod0;
        n_sat1     = (w_prod1 >= SAT_PRE8) ? SAT_LIM : {w_prod1[60:0], 3'b000};
        n_sq_sum   = {1'b0, w_prod0} + {1'b0, w_prod1};
        n_dsum_s   = (SUM_W+1)'(r_dsum) + $signed({1'b0, (SUM_W)'(r_dist)});
        n_hsum_s   = (SUM_W+1)'(r_hsum) + (SUM_W+1)'(r_head);
    end

    // Signed PID terms for the phase that just finished.
    always_comb begin
        case (r_phase)
            PH_PROP: begin
                n_term0 = $signed(w_prod0);
                n_term1 = r_head[15] ? -$signed(w_prod1) : $signed(w_prod1);
            end
            PH_RATE: begin
                n_term0 = n_dd[32] ? -$signed(w_prod0) : $signed(w_prod0);
                n_term1 = n_dh[16] ? -$signed(w_prod1) : $signed(w_prod1);
            end
            PH_INTEG: begin
                n_term0 = r_dsum[SUM_W-1] ? -$signed(n_sat0) : $signed(n_sat0);
                n_term1 = r_hsum[SUM_W-1] ? -$signed(n_sat1) : $signed(n_sat1);
            end
            default: begin
                n_term0 = '0;
                n_term1 = '0;
            end
        endcase
    end

    // Multiplier commands: squares at load, PID products per phase.
    always_comb begin
        n_cmd0 = '0;
        n_cmd1 = '0;
        if (r_state == S_LOAD) begin
            n_cmd0.start = 1'b1;
            n_cmd0.nbits = SQ_BITS;
            n_cmd0.a     = MUL_A_W'(n_ax);
            n_cmd0.b     = MUL_B_W'(n_ax);
            n_cmd1.start = 1'b1;
            n_cmd1.nbits = SQ_BITS;
            n_cmd1.a     = MUL_A_W'(n_ay);
            n_cmd1.b     = MUL_B_W'(n_ay);
        end else if (r_state == S_GO) begin
            n_cmd0.start = 1'b1;
            n_cmd1.start = 1'b1;
            case (r_phase)
                PH_PROP: begin
                    n_cmd0.nbits = GAIN_BITS;
                    n_cmd0.a     = MUL_A_W'(r_dist);
                    n_cmd0.b     = MUL_B_W'(r_prop_gain);
                    n_cmd1.nbits = GAIN_BITS;
                    n_cmd1.a     = MUL_A_W'({n_head_mag, 3'b000});
                    n_cmd1.b     = MUL_B_W'(r_prop_gain);
                end
                PH_DERIV: begin
                    n_cmd0.nbits = GAIN_BITS;
                    n_cmd0.a     = MUL_A_W'(n_dd_mag);
                    n_cmd0.b     = MUL_B_W'(r_deriv_gain);
                    n_cmd1.nbits = GAIN_BITS;
                    n_cmd1.a     = MUL_A_W'({n_dh_mag, 3'b000});
                    n_cmd1.b     = MUL_B_W'(r_deriv_gain);
                end
                PH_RATE: begin
                    n_cmd0.nbits = RATE_BITS;
                    n_cmd0.a     = w_prod0;
                    n_cmd0.b     = MUL_B_W'(r_tick_rate);
                    n_cmd1.nbits = RATE_BITS;
                    n_cmd1.a     = w_prod1;
                    n_cmd1.b     = MUL_B_W'(r_tick_rate);
                end
                default: begin
                    n_cmd0.nbits = GAIN_BITS;
                    n_cmd0.a     = MUL_A_W'(n_dsum_mag);
                    n_cmd0.b     = MUL_B_W'(r_integ_gain);
                    n_cmd1.nbits = GAIN_BITS;
                    n_cmd1.a     = MUL_A_W'(n_hsum_mag);
                    n_cmd1.b     = MUL_B_W'(r_integ_gain);
                end
            endcase
        end
    end

    wps_smul u_mul_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd0),
        .o_busy  (w_busy0),
        .o_prod  (w_prod0)
    );

    wps_smul u_mul_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (n_cmd1),
        .o_busy  (w_busy1),
        .o_prod  (w_prod1)
    );

    // Square root step, CORDIC step, heading rounding and drive sums.
    always_comb begin
        n_rem_sh    = {r_rem[34:0], r_rad[65:64]};
        n_trial     = {2'b00, r_root, 2'b01};
        n_theta_ext = {{2{r_theta[15]}}, r_theta, 17'b0};
        n_e_rnd     = r_e + 35'sd65536;
        n_xs        = r_cx >>> r_cstep;
        n_ys        = r_cy >>> r_cstep;
        n_sx        = 36'(r_dx);
        n_sy        = 36'(r_dy);
        n_at        = 35'(atan_q30(r_cstep));
        n_ul        = r_common - r_turn;
        n_ur        = r_common + r_turn;
        n_rl        = n_ul + 64'sd32768;
        n_rr        = n_ur + 64'sd32768;
    end

    // Bearing by CORDIC vectoring, after folding into the right half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbusy <= 1'b0;
        end else if (r_state == S_LOAD) begin
            r_cstep <= '0;
            if (r_dx == '0 && r_dy == '0) begin
                r_cbusy <= 1'b0;
                r_cz    <= '0;
            end else begin
                r_cbusy <= 1'b1;
                if (r_dx[32]) begin
                    r_cx <= -n_sx;
                    r_cy <= -n_sy;
                    r_cz <= r_dy[32] ? -PI_Q30 : PI_Q30;
                end else begin
                    r_cx <= n_sx;
                    r_cy <= n_sy;
                    r_cz <= '0;
                end
            end
        end else if (r_cbusy) begin
            if (!r_cy[35] && r_cy != '0) begin
                r_cx <= r_cx + n_ys;
                r_cy <= r_cy - n_xs;
                r_cz <= r_cz + n_at;
            end else begin
                r_cx <= r_cx - n_ys;
                r_cy <= r_cy + n_xs;
                r_cz <= r_cz - n_at;
            end
            r_cstep <= r_cstep + 1'b1;
            if (r_cstep == 5'(CORDIC_STEPS-1)) begin
                r_cbusy <= 1'b0;
            end
        end
    end

    // Main sequencer, datapath and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_PROP;
            r_ovalid     <= 1'b0;
            r_prev_dist  <= '0;
            r_prev_head  <= '0;
            r_dsum       <= '0;
            r_hsum       <= '0;
            r_prev_left  <= '0;
            r_prev_right <= '0;
        end else begin
            // A taken result empties the output register unless a new one replaces it.
            if (r_ovalid && i_out_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.op;
                        r_theta <= i_in_data.pose_theta;
                        r_dx    <= 33'(i_in_data.goal_x) - 33'(i_in_data.pose_x);
                        r_dy    <= 33'(i_in_data.goal_y) - 33'(i_in_data.pose_y);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_SQR;
                end
                S_SQR: begin
                    if (!w_busy0 && !w_busy1 && !r_cbusy) begin
                        r_rad   <= {1'b0, n_sq_sum};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_scnt  <= SQ_BITS;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    // One root bit per cycle, two radicand bits brought down.
                    if (n_rem_sh >= n_trial) begin
                        r_rem  <= n_rem_sh - n_trial;
                        r_root <= {r_root[31:0], 1'b1};
                    end else begin
                        r_rem  <= n_rem_sh;
                        r_root <= {r_root[31:0], 1'b0};
                    end
                    r_rad  <= {r_rad[63:0], 2'b00};
                    r_scnt <= r_scnt - 1'b1;
                    if (r_scnt == 6'd1) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_dist  <= r_root[32] ? 32'hFFFF_FFFF : r_root[31:0];
                    r_e     <= r_cz - n_theta_ext;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // Bring the heading error into the half-open range up to pi.
                    if (r_e > PI_Q30) begin
                        r_e <= r_e - TWO_PI_Q30;
                    end else if (r_e <= -PI_Q30) begin
                        r_e <= r_e + TWO_PI_Q30;
                    end else begin
                        r_head  <= n_e_rnd[32:17];
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    // A new waypoint restarts the loop from this tick's errors.
                    if (r_op) begin
                        r_prev_dist  <= r_dist;
                        r_prev_head  <= r_head;
                        r_dsum       <= '0;
                        r_hsum       <= '0;
                        r_prev_left  <= '0;
                        r_prev_right <= '0;
                    end
                    r_phase <= PH_PROP;
                    r_state <= S_GO;
                end
                S_GO: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!w_busy0 && !w_busy1) begin
                        if (r_phase == PH_PROP) begin
                            r_common <= n_term0;
                            r_turn   <= n_term1;
                        end else begin
                            r_common <= r_common + n_term0;
                            r_turn   <= r_turn + n_term1;
                        end
                        case (r_phase)
                            PH_PROP:  begin
                                r_phase <= PH_DERIV;
                                r_state <= S_GO;
                            end
                            PH_DERIV: begin
                                r_phase <= PH_RATE;
                                r_state <= S_GO;
                            end
                            PH_RATE:  begin
                                r_phase <= PH_INTEG;
                                r_state <= S_GO;
                            end
                            default:  begin
                                r_state <= S_DRIVE;
                            end
                        endcase
                    end
                end
                S_DRIVE: begin
                    r_vl    <= clamp_speed(n_rl, r_speed_limit);
                    r_vr    <= clamp_speed(n_rr, r_speed_limit);
                    r_state <= S_SLEW;
                end
                S_SLEW: begin
                    r_vl    <= slew(r_vl, r_prev_left, r_accel_limit);
                    r_vr    <= slew(r_vr, r_prev_right, r_accel_limit);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hand the result over and update the loop state.
                    if (!r_ovalid || i_out_ready) begin
                        r_out.drive_left     <= r_vl;
                        r_out.drive_right    <= r_vr;
                        r_out.distance_error <= r_dist;
                        r_out.heading_error  <= r_head;
                        r_out.arrived        <= (r_dist < {16'b0, r_arrive_thr});
                        r_ovalid             <= 1'b1;
                        r_prev_dist          <= r_dist;
                        r_prev_head          <= r_head;
                        r_dsum               <= sat_sum(n_dsum_s);
                        r_hsum               <= sat_sum(n_hsum_s);
                        r_prev_left          <= r_vl;
                        r_prev_right         <= r_vr;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Register writes from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= 16'd2100;
            r_integ_gain  <= 16'd1;
            r_deriv_gain  <= 16'd22;
            r_tick_rate   <= 10'd20;
            r_speed_limit <= 15'd200;
            r_accel_limit <= 15'd13;
            r_arrive_thr  <= 16'd1311;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_PROP_GAIN:   r_prop_gain   <= pwdata[15:0];
                REG_INTEG_GAIN:  r_integ_gain  <= pwdata[15:0];
                REG_DERIV_GAIN:  r_deriv_gain  <= pwdata[15:0];
                REG_TICK_RATE:   r_tick_rate   <= pwdata[9:0];
                REG_SPEED_LIMIT: r_speed_limit <= pwdata[14:0];
                REG_ACCEL_LIMIT: r_accel_limit <= pwdata[14:0];
                REG_ARRIVE_THR:  r_arrive_thr  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[4:2])
            REG_PROP_GAIN:   prdata = 32'(r_prop_gain);
            REG_INTEG_GAIN:  prdata = 32'(r_integ_gain);
            REG_DERIV_GAIN:  prdata = 32'(r_deriv_gain);
            REG_TICK_RATE:   prdata = 32'(r_tick_rate);
            REG_SPEED_LIMIT: prdata = 32'(r_speed_limit);
            REG_ACCEL_LIMIT: prdata = 32'(r_accel_limit);
            REG_ARRIVE_THR:  prdata = 32'(r_arrive_thr);
            default:         prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the waypoint PID steering block.
`timescale 1ns / 1ps

module tb;
    import wps_pkg::*;

    localparam longint HALF_TURN = 64'sd3373259426;
    localparam logic [63:0] PROD_CAP = 64'h1000_0000_0000_0000;
    localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
    localparam longint ACC_MIN = -(64'sd1 <<< 47);

    // Arctangent of 2^-i in Q2.30 for the bearing steps.
    localparam longint ARC_STEP [0:15] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_in_req in_data;
    logic out_valid;
    logic out_ready;
    t_out_req out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    waypoint_pid_steering_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor copy of the registers and the controller state.
    longint gain_reg [0:6];
    longint last_dist, last_head, dist_acc, head_acc, last_left, last_right;

    t_in_req  tick_q [$];
    t_out_req steer_q [$];
    int send_idle, recv_idle;
    int fail_cnt, tick_cnt, result_cnt;
    logic holding;

    // Free-running clock; reset is applied once, at the start of the stimulus.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // CORDIC vectoring bearing in Q2.30, folded into the right half plane first.
    function automatic longint bearing(input longint x, input longint y);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ARC_STEP[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARC_STEP[i];
            end
        end
        return z;
    endfunction

    // Product whose magnitude saturates at 2^60.
    function automatic longint scale_sat(input longint a, input longint k);
        logic [63:0] m, kk;
        logic neg;
        neg = a < 0;
        m = neg ? -a : a;
        kk = k;
        if (kk != 0 && m > PROD_CAP / kk) m = PROD_CAP;
        else m = m * kk;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint acc_add(input longint a, input longint b);
        if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
        if (b < 0 && a < ACC_MIN - b) return ACC_MIN;
        return a + b;
    endfunction

    // Round to a drive unit, clamp to the speed limit, then slew-limit.
    function automatic longint wheel_cmd(input longint u, input longint last);
        longint v;
        v = (u + 32768) >>> 16;
        if (v > gain_reg[REG_SPEED_LIMIT]) v = gain_reg[REG_SPEED_LIMIT];
        if (v < -gain_reg[REG_SPEED_LIMIT]) v = -gain_reg[REG_SPEED_LIMIT];
        if (v > last + gain_reg[REG_ACCEL_LIMIT]) v = last + gain_reg[REG_ACCEL_LIMIT];
        if (v < last - gain_reg[REG_ACCEL_LIMIT]) v = last - gain_reg[REG_ACCEL_LIMIT];
        return v;
    endfunction

    // Work out the steering result of one tick and advance the controller state.
    function automatic t_out_req steer_predict(input t_in_req t);
        longint dx, dy, e, head, common, turn, vl, vr, kp, ki, kd, rate;
        logic [63:0] ax, ay, ax2, ay2, span;
        t_out_req r;
        kp = gain_reg[REG_PROP_GAIN];
        ki = gain_reg[REG_INTEG_GAIN];
        kd = gain_reg[REG_DERIV_GAIN];
        rate = gain_reg[REG_TICK_RATE];
        dx = longint'(t.goal_x) - longint'(t.pose_x);
        dy = longint'(t.goal_y) - longint'(t.pose_y);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        ax2 = ax * ax;
        ay2 = ay * ay;
        if (ax2 > ~64'd0 - ay2) span = 64'hFFFF_FFFF;
        else span = root_floor(ax2 + ay2);
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        e = bearing(dx, dy) - longint'(t.pose_theta) * 131072;
        while (e > HALF_TURN) e = e - 2 * HALF_TURN;
        while (e <= -HALF_TURN) e = e + 2 * HALF_TURN;
        head = (e + 65536) >>> 17;
        // A new waypoint seeds the last errors and clears the history.
        if (t.op) begin
            last_dist = longint'(span);
            last_head = head;
            dist_acc = 0;
            head_acc = 0;
            last_left = 0;
            last_right = 0;
        end
        common = scale_sat(longint'(span), kp)
               + scale_sat(scale_sat(longint'(span) - last_dist, kd), rate)
               + scale_sat(dist_acc, ki);
        turn = scale_sat(head * 8, kp)
             + scale_sat(scale_sat((head - last_head) * 8, kd), rate)
             + scale_sat(scale_sat(head_acc, ki), 8);
        vl = wheel_cmd(common - turn, last_left);
        vr = wheel_cmd(common + turn, last_right);
        last_dist = longint'(span);
        last_head = head;
        dist_acc = acc_add(dist_acc, longint'(span));
        head_acc = acc_add(head_acc, head);
        last_left = vl;
        last_right = vr;
        r.drive_left = vl[15:0];
        r.drive_right = vr[15:0];
        r.distance_error = span[31:0];
        r.heading_error = head[15:0];
        r.arrived = span < gain_reg[REG_ARRIVE_THR];
        return r;
    endfunction

    // Request driver: presents queued ticks, with random gaps and drain pauses.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            holding <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                steer_q.push_back(steer_predict(in_data));
                tick_cnt <= tick_cnt + 1;
            end
            if (!in_valid || in_ready) begin
                if (holding) begin
                    in_valid <= 1'b0;
                    if (steer_q.size() == 0) holding <= 1'b0;
                end else if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    in_valid <= 1'b1;
                    in_data <= tick_q.pop_front();
                    if ($urandom_range(59) == 0) holding <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint exp_v, input longint got_v);
        if (exp_v != got_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= $urandom_range(99) >= recv_idle;
            if (out_valid && out_ready) begin
                result_cnt <= result_cnt + 1;
                if (steer_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = steer_q.pop_front();
                    check_field("drive_left", want.drive_left, out_data.drive_left);
                    check_field("drive_right", want.drive_right, out_data.drive_right);
                    check_field("distance_error", want.distance_error,
                                out_data.distance_error);
                    check_field("heading_error", want.heading_error, out_data.heading_error);
                    check_field("arrived", want.arrived, out_data.arrived);
                end
            end
        end
    end

    // Register write: setup cycle then access cycle.
    task automatic reg_write(input logic [2:0] idx, input longint value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= value[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gain_reg[idx] = value;
    endtask

    task automatic wait_idle();
        while (!(tick_q.size() == 0 && !in_valid && steer_q.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_tick(input logic op, input longint tx, input longint ty,
                            input longint px, input longint py, input longint th);
        t_in_req t;
        t.op = op;
        t.goal_x = tx[31:0];
        t.goal_y = ty[31:0];
        t.pose_x = px[31:0];
        t.pose_y = py[31:0];
        t.pose_theta = th[15:0];
        tick_q.push_back(t);
    endtask

    function automatic longint rand_coord();
        return longint'(int'($urandom)) >>> $urandom_range(24, 0);
    endfunction

    // A waypoint approach: start tick, then the pose closes in on the target.
    task automatic add_route(input int len);
        longint tx, ty, px, py, th;
        tx = rand_coord();
        ty = rand_coord();
        px = rand_coord();
        py = rand_coord();
        th = longint'(shortint'($urandom));
        for (int k = 0; k < len; k++) begin
            add_tick(k == 0, tx, ty, px, py, th);
            px = px + (tx - px) / longint'($urandom_range(8, 2))
               + longint'($urandom_range(64)) - 32;
            py = py + (ty - py) / longint'($urandom_range(8, 2))
               + longint'($urandom_range(64)) - 32;
            if (px > 32'sh7FFF_FFFF || px < -32'sh8000_0000) px = tx;
            if (py > 32'sh7FFF_FFFF || py < -32'sh8000_0000) py = ty;
            th = longint'(shortint'(th + longint'($urandom_range(2000)) - 1000));
        end
    endtask

    task automatic add_random_ticks(input int n);
        int left;
        left = n;
        while (left > 0) begin
            if ($urandom_range(99) < 20) begin
                add_tick(1'($urandom_range(1)), longint'(int'($urandom)),
                         longint'(int'($urandom)),
                         longint'(int'($urandom)), longint'(int'($urandom)),
                         longint'(shortint'($urandom)));
                left--;
            end else begin
                add_route($urandom_range(20, 3));
                left -= 12;
            end
        end
    endtask

    // Register settings per phase: gains, rate, limits, threshold.
    longint phase_set [0:7][0:6] = '{
        '{65535, 65535, 65535, 1000, 32767, 32767, 65535},
        '{0, 0, 0, 0, 0, 0, 0},
        '{500, 3, 40, 50, 1000, 100, 20000},
        '{2100, 1, 22, 20, 200, 13, 1311},
        '{2100, 1, 22, 20, 30, 5, 1311},
        '{30000, 200, 300, 1, 32767, 2000, 65535},
        '{1, 65535, 1, 1000, 5000, 32767, 0},
        '{0, 0, 0, 0, 0, 0, 0}};

    // Stimulus sequence.
    initial begin
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        holding = 1'b0;
        fail_cnt = 0;
        tick_cnt = 0;
        result_cnt = 0;
        send_idle = 12;
        recv_idle = 46;
        gain_reg = '{2100, 1, 22, 20, 200, 13, 1311};
        last_dist = 0; last_head = 0; dist_acc = 0; head_acc = 0;
        last_left = 0; last_right = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks under the reset settings.
        add_tick(1'b0, 0, 0, 0, 0, 0);
        add_tick(1'b1, 0, 0, 0, 0, 0);
        add_tick(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh8000_0000, -32'sh8000_0000, 0);
        add_tick(1'b0, -32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 32767);
        add_tick(1'b1, -65536, 0, 0, 0, -32768);
        add_tick(1'b0, -65536, -1, 0, 0, 32767);
        add_tick(1'b0, 0, 65536, 0, 0, 0);
        add_tick(1'b0, 0, -65536, 0, 0, -32768);
        add_tick(1'b1, 655360, 327680, 0, 0, 0);
        add_tick(1'b0, 655360, 327680, 65536, 0, 4096);
        add_tick(1'b0, 655360, 327680, 131072, 65536, -4096);
        add_tick(1'b0, 655360, 327680, 655000, 327680, 0);
        add_tick(1'b0, 100, 100, 0, 0, 25736);
        add_tick(1'b0, 32'sh7FFF_FFFF, 0, 0, 0, -25736);
        add_tick(1'b1, 1, 1, 0, 0, 0);
        add_random_ticks(60);
        wait_idle();

        // Random phases across register settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                for (int j = 0; j < 7; j++) phase_set[7][j] = $urandom_range(65535);
                phase_set[7][REG_TICK_RATE] = $urandom_range(1000, 1);
                phase_set[7][REG_SPEED_LIMIT] = $urandom_range(32767);
                phase_set[7][REG_ACCEL_LIMIT] = $urandom_range(32767);
            end
            for (int j = 0; j < 7; j++) reg_write(j[2:0], phase_set[ph][j]);
            if (ph < 3) begin
                send_idle = 12; recv_idle = 46;
            end else if (ph < 5) begin
                send_idle = 46; recv_idle = 12;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            add_random_ticks(80);
            wait_idle();
        end

        repeat (300) @(posedge i_clk);
        if (steer_q.size() != 0) begin
            $error("%0d results never arrived", steer_q.size());
            fail_cnt++;
        end
        $display("Ran %0d ticks and checked %0d results over 9 register settings,",
                 tick_cnt, result_cnt);
        $display("including waypoint starts, saturated distances and zero gains.");
        if (fail_cnt == 0) begin
            $display("waypoint_pid_steering_top: match");
        end else begin
            $display("waypoint_pid_steering_top: mismatch");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20ms;
        $display("waypoint_pid_steering_top: mismatch");
        $finish;
    end

endmodule
